// ===== hw/rtl/dq_pkg.sv =====
package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int ITEM_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                latch;
        logic                push;
        logic                pop;
        logic                dump_start;
        logic                dump_next;
        logic                out_load;
        logic                out_mem;
        logic                out_last;
        logic [STATUS_W-1:0] out_status;
    } dq_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             out_free;
        logic             dump_last;
    } dq_stat_t;

endpackage

// ===== hw/rtl/dq_datapath.sv =====
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dq_pkg::dq_ctrl_t                  ctrl,
    output dq_pkg::dq_stat_t                  stat,
    input  logic [dq_pkg::CMD_W-1:0]          cmd,
    input  logic signed [dq_pkg::ITEM_W-1:0]  item_value,
    output logic [dq_pkg::STATUS_W-1:0]       status,
    output logic signed [dq_pkg::ITEM_W-1:0]  out_value,
    output logic                              last,
    output logic                              res_valid,
    input  logic                              res_stall
);
    import dq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [ITEM_W-1:0]   mem [DEPTH];
    logic [CMD_W-1:0]    cmd_reg;
    logic [ITEM_W-1:0]   val_reg;
    logic [PW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PW-1:0]       idx_reg, idx_next;
    logic [ITEM_W-1:0]   rd_data_reg;
    logic                res_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ITEM_W-1:0]   value_reg;
    logic                last_reg;

    logic          at_front;
    logic [PW-1:0] front_dec;
    logic [PW:0]   count_ext;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic          out_free;

    // Ring position base + off, where off is at most DEPTH.
    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                               input logic [PW:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[PW-1:0];
    endfunction

    assign at_front  = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_POP_FRONT);
    assign front_dec = (front_reg == '0) ? LAST_POS : front_reg - 1'b1;
    assign count_ext = (PW + 1)'(count_reg);
    assign out_free  = !res_valid_reg || !res_stall;
    assign wr_en     = ctrl.push;
    assign wr_addr   = at_front ? front_dec : ring_add(front_reg, count_ext);
    assign rd_en     = ctrl.pop || ctrl.dump_start || ctrl.dump_next;

    always_comb
    begin
        rd_addr = front_reg;
        if (ctrl.pop && !at_front)
        begin
            rd_addr = ring_add(front_reg, count_ext - 1'b1);
        end
        else if (ctrl.dump_next)
        begin
            rd_addr = ring_add(front_reg, {1'b0, idx_reg} + 1'b1);
        end
    end

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
            if (at_front)
            begin
                front_next = front_dec;
            end
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
            if (at_front)
            begin
                front_next = ring_add(front_reg, (PW + 1)'(1));
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.dump_start)
        begin
            idx_next = '0;
        end
        else if (ctrl.dump_next)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            if (ctrl.out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctrl.latch)
        begin
            cmd_reg <= cmd;
            val_reg <= item_value;
        end
        if (ctrl.out_load)
        begin
            status_reg <= ctrl.out_status;
            value_reg  <= ctrl.out_mem ? rd_data_reg : '0;
            last_reg   <= ctrl.out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == FULL_CNT);
    assign stat.out_free  = out_free;
    assign stat.dump_last = (({1'b0, idx_reg} + 1'b1) == count_ext);

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign out_value = value_reg;
    assign last      = last_reg;

endmodule

// ===== hw/rtl/dq_ctrl.sv =====
module dq_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  logic [dq_pkg::CMD_W-1:0] cmd,
    input  dq_pkg::dq_stat_t         stat,
    output dq_pkg::dq_ctrl_t         ctrl
);
    import dq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_POPOUT = 2'd2;
    localparam logic [1:0] S_DUMP   = 2'd3;

    logic [1:0] state_reg, state_next;

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.latch = cmd_valid;
                // Undefined commands are taken and dropped without a result.
                if (cmd_valid && (cmd <= CMD_DUMP))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.cmd) inside
                    CMD_PUSH_FRONT, CMD_PUSH_REAR:
                    begin
                        if (stat.out_free)
                        begin
                            ctrl.out_load   = 1'b1;
                            ctrl.out_last   = 1'b1;
                            ctrl.out_status = stat.full ? STATUS_FULL : STATUS_OK;
                            ctrl.push       = !stat.full;
                            state_next      = S_IDLE;
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_REAR, CMD_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            if (stat.out_free)
                            begin
                                ctrl.out_load   = 1'b1;
                                ctrl.out_last   = 1'b1;
                                ctrl.out_status = STATUS_EMPTY;
                                state_next      = S_IDLE;
                            end
                        end
                        else if (stat.cmd == CMD_DUMP)
                        begin
                            ctrl.dump_start = 1'b1;
                            state_next      = S_DUMP;
                        end
                        else
                        begin
                            ctrl.pop   = 1'b1;
                            state_next = S_POPOUT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POPOUT:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load   = 1'b1;
                    ctrl.out_mem    = 1'b1;
                    ctrl.out_last   = 1'b1;
                    ctrl.out_status = STATUS_OK;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP:
            begin
                // The next item is read in the same cycle the current one is loaded out.
                if (stat.out_free)
                begin
                    ctrl.out_load   = 1'b1;
                    ctrl.out_mem    = 1'b1;
                    ctrl.out_last   = stat.dump_last;
                    ctrl.out_status = STATUS_OK;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctrl.dump_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit items held in a ring memory.
// Command channel: cmd_valid/cmd_stall with cmd and item_value. Commands are
// push front, pop front, push rear, pop rear and dump; other codes are taken
// and ignored. Result channel: res_valid/res_stall with status, out_value and
// last. Every push, pop and dump gives one result, except a dump of a non-empty
// queue, which gives one result per stored item from front to rear, last on
// the final one.
// Steps: a push, or a pop or dump on an empty queue, is latched in S_IDLE and
// loads its result into the output register in S_EXEC. A pop reads the memory
// in S_EXEC and loads the registered read data in S_POPOUT. A dump reads the
// front item in S_EXEC, then in S_DUMP loads each item while reading the next,
// and streams one item per cycle through the single memory read port while
// the receiver does not stall. An ignored command is dropped in S_IDLE.
// The result sits in an output register, so the next command is accepted
// while an earlier result still waits. When the receiver stalls, the
// controller holds its state until the output register is free.
// Reset empties the queue at once; the memory needs no clearing pass.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [dq_pkg::CMD_W-1:0]          cmd,
    input  logic signed [dq_pkg::ITEM_W-1:0]  item_value,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [dq_pkg::STATUS_W-1:0]       status,
    output logic signed [dq_pkg::ITEM_W-1:0]  out_value,
    output logic                              last
);
    import dq_pkg::*;

    dq_ctrl_t ctrl;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .cmd        (cmd),
        .item_value (item_value),
        .status     (status),
        .out_value  (out_value),
        .last       (last),
        .res_valid  (res_valid),
        .res_stall  (res_stall)
    );

endmodule

// ===== hw/rtl/dq_checker.sv =====
module dq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_stall,
    input logic [dq_pkg::CMD_W-1:0]          cmd,
    input logic                              res_valid,
    input logic                              res_stall,
    input logic [dq_pkg::STATUS_W-1:0]       status,
    input logic signed [dq_pkg::ITEM_W-1:0]  out_value,
    input logic                              last
);
    import dq_pkg::*;

    // A stalled result must hold.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(status)
            && $stable(out_value) && $stable(last))
        else $error("stalled result changed");

    // A valid command keeps the block busy in the following cycle.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd <= CMD_DUMP) |=> cmd_stall)
        else $error("command accepted without busy cycle");

    // Empty and full results stand alone.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != STATUS_OK) |-> last)
        else $error("error status on a non-final result");

    // Empty and full results carry no item.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != STATUS_OK) |-> (out_value == '0))
        else $error("error status with non-zero value");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int QD = DEPTH_DEFAULT;
    localparam int RANDOM_CMDS = 310;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = QD + 8;

    // Command codes that the block takes and ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [ITEM_W-1:0]  value;
        logic                      last;
    } result_t;

    typedef struct {
        logic [CMD_W-1:0]          op;
        logic signed [ITEM_W-1:0]  val;
        int                        reps;
        bit                        typed;
        logic [STATUS_W-1:0]       want_status;
        logic signed [ITEM_W-1:0]  want_value;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cmd_valid = 1'b0;
    logic                       cmd_stall;
    logic [CMD_W-1:0]           cmd = '0;
    logic signed [ITEM_W-1:0]   item_value = '0;
    logic                       res_valid;
    logic                       res_stall = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [ITEM_W-1:0]   out_value;
    logic                       last;

    // Own copy of the ring, its front position and its fill level.
    logic signed [ITEM_W-1:0]   ring [QD];
    int                         head = 0;
    int                         held = 0;

    result_t                    step_results[$];
    result_t                    expected_results[$];
    int                         fail_count = 0;
    int                         idle_cycles = 0;
    int                         stall_left = 0;
    bit                         calm = 1'b0;

    stim_row_t directed_rows [23] = '{
        '{CMD_POP_FRONT,  32'sh0000_0000,  1, 1'b1, STATUS_EMPTY, 32'sh0},
        '{CMD_POP_REAR,   32'sh0000_0000,  1, 1'b1, STATUS_EMPTY, 32'sh0},
        '{CMD_DUMP,       32'sh0000_0000,  1, 1'b1, STATUS_EMPTY, 32'sh0},
        '{CMD_PUSH_FRONT, 32'sh7fff_ffff,  1, 1'b1, STATUS_OK,    32'sh0},
        '{CMD_PUSH_REAR,  32'sh8000_0000,  1, 1'b1, STATUS_OK,    32'sh0},
        '{CMD_PUSH_FRONT, 32'shffff_ffff,  1, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_PUSH_REAR,  32'sh0000_0000,  1, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_DUMP,       32'sh1234_5678,  1, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_POP_FRONT,  32'sh0000_0000,  1, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_POP_REAR,   32'shffff_ffff,  1, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_SPARE_5,    32'sh0000_0000,  1, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_SPARE_6,    32'sh5555_aaaa,  1, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_SPARE_7,    32'shffff_ffff,  1, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_PUSH_REAR,  32'sh5a5a_0000, 14, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_PUSH_FRONT, 32'sh0bad_0001,  1, 1'b1, STATUS_FULL,  32'sh0},
        '{CMD_PUSH_REAR,  32'sh0bad_0002,  1, 1'b1, STATUS_FULL,  32'sh0},
        '{CMD_DUMP,       32'sh0000_0000,  1, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_POP_REAR,   32'sh0000_0000,  8, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_POP_FRONT,  32'sh0000_0000,  8, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_POP_FRONT,  32'sh0000_0000,  1, 1'b1, STATUS_EMPTY, 32'sh0},
        '{CMD_DUMP,       32'sh0000_0000,  1, 1'b1, STATUS_EMPTY, 32'sh0},
        '{CMD_PUSH_FRONT, 32'sh1357_9bdf,  5, 1'b0, STATUS_OK,    32'sh0},
        '{CMD_POP_REAR,   32'sh0000_0000,  5, 1'b0, STATUS_OK,    32'sh0}
    };

    double_ended_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .item_value (item_value),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .status     (status),
        .out_value  (out_value),
        .last       (last)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic void add_result(logic [STATUS_W-1:0] st, logic signed [ITEM_W-1:0] v,
                                       logic lst);
        step_results.push_back(result_t'{st, v, lst});
    endfunction

    // Applies one command to the model of the queue and collects the results it causes.
    function automatic void apply_deque_cmd(logic [CMD_W-1:0] op, logic signed [ITEM_W-1:0] val);
        int pos;
        step_results.delete();
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (held >= QD)
                begin
                    add_result(STATUS_FULL, '0, 1'b1);
                end
                else
                begin
                    if (op == CMD_PUSH_FRONT)
                    begin
                        head = (head + QD - 1) % QD;
                        ring[head] = val;
                    end
                    else
                    begin
                        ring[(head + held) % QD] = val;
                    end
                    held++;
                    add_result(STATUS_OK, '0, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR:
            begin
                if (held == 0)
                begin
                    add_result(STATUS_EMPTY, '0, 1'b1);
                end
                else
                begin
                    if (op == CMD_POP_FRONT)
                    begin
                        pos = head;
                        head = (head + 1) % QD;
                    end
                    else
                    begin
                        pos = (head + held - 1) % QD;
                    end
                    held--;
                    add_result(STATUS_OK, ring[pos], 1'b1);
                end
            end
            CMD_DUMP:
            begin
                if (held == 0)
                begin
                    add_result(STATUS_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        add_result(STATUS_OK, ring[(head + i) % QD], i == held - 1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [ITEM_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return 32'shffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_op(bit filling);
        int r;
        bit push_side;
        r = $urandom_range(0, 99);
        push_side = $urandom_range(0, 1);
        if (r < 3)
        begin
            case ($urandom_range(0, 2))
                0: return CMD_SPARE_5;
                1: return CMD_SPARE_6;
                default: return CMD_SPARE_7;
            endcase
        end
        if (r < 11)
            return CMD_DUMP;
        if ((r < 71) == filling)
            return push_side ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        return push_side ? CMD_POP_FRONT : CMD_POP_REAR;
    endfunction

    task automatic send_cmd(logic [CMD_W-1:0] op, logic signed [ITEM_W-1:0] val);
        cmd_valid <= 1'b1;
        cmd <= op;
        item_value <= val;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic issue(logic [CMD_W-1:0] op, logic signed [ITEM_W-1:0] val, bit typed,
                         result_t want);
        int gap;
        apply_deque_cmd(op, val);
        if (typed)
            expected_results.push_back(want);
        else
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
        send_cmd(op, val);
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm <= ~calm;
        end
    end

    // The receiver stalls in bursts; no new burst starts while calm.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_stall <= 1'b0;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status %0d value %0d last %0d",
                             status, out_value, last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status || out_value !== want.value || last !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.status, want.value, want.last, status, out_value, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int counted;
        bit filling;
        logic [CMD_W-1:0] op;
        result_t want;
        counted = 0;
        filling = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            want = result_t'{directed_rows[r].want_status, directed_rows[r].want_value, 1'b1};
            for (int k = 0; k < directed_rows[r].reps; k++)
                issue(directed_rows[r].op, directed_rows[r].val + k, directed_rows[r].typed, want);
        end
        drain_results();

        // Alternate between filling and draining so that both bounds are met often.
        while (counted < RANDOM_CMDS)
        begin
            if ((filling && held == QD) || (!filling && held == 0))
            begin
                if ($urandom_range(0, 2) == 0)
                    filling = ~filling;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                filling = ~filling;
            end
            op = pick_op(filling);
            issue(op, pick_value(), 1'b0, want);
            if (op <= CMD_DUMP)
            begin
                counted++;
                if (counted == RANDOM_CMDS / 2)
                    drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dq_pkg.sv
hw/rtl/dq_datapath.sv
hw/rtl/dq_ctrl.sv
hw/rtl/double_ended_queue.sv
hw/rtl/dq_checker.sv
tb/tb_top.sv
